// ===== src/rsfe_pkg.sv =====
// rsfe_pkg: symbol codes, field widths and frame construction for the
// remote-switch frame encoder; no dependencies
package rsfe_pkg;

    // frame geometry
    localparam int NUM_SYMBOLS  = 16;
    localparam int SYM_W        = 8;
    localparam int SYM_IDX_W    = $clog2(NUM_SYMBOLS);
    localparam int BIT_IDX_W    = $clog2(SYM_W);
    localparam int DEV_W        = 5;
    localparam int SUB_W        = 3;
    localparam int REPEAT_W     = 8;

    // symbol index layout
    localparam logic [SYM_IDX_W-1:0] SUB_BASE  = 4'd5;
    localparam logic [SYM_IDX_W-1:0] ON_IDX_A  = 4'd10;
    localparam logic [SYM_IDX_W-1:0] ON_IDX_B  = 4'd11;
    localparam logic [SYM_IDX_W-1:0] SYNC_IDX  = 4'd12;
    localparam logic [SYM_IDX_W-1:0] LAST_SYM  = 4'd15;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT  = 3'd7;

    // symbol codes, shifted out msb first
    localparam logic [SYM_W-1:0] SYM_LOW   = 8'h88;
    localparam logic [SYM_W-1:0] SYM_HIGH  = 8'hEE;
    localparam logic [SYM_W-1:0] SYM_FLOAT = 8'h8E;
    localparam logic [SYM_W-1:0] SYM_SYNC  = 8'h80;
    localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h00;

    // operation codes carried in tuser
    localparam logic OP_SEND = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // highest sub-address that is taken
    localparam logic [SUB_W-1:0] SUB_ADDR_MAX = 3'd4;

    // configuration register indexes and reset value
    localparam logic REG_REPEAT_COUNT = 1'b0;
    localparam logic [REPEAT_W-1:0] REPEAT_COUNT_RESET = 8'd4;

    typedef logic [SYM_W-1:0] symbol_t;

    // one symbol of a freshly built frame
    function automatic symbol_t build_symbol(input logic [SYM_IDX_W-1:0] idx,
                                             input logic [DEV_W-1:0]     dev,
                                             input logic [SUB_W-1:0]     sub,
                                             input logic                 on);
        symbol_t sym;
        logic [SYM_IDX_W-1:0] sub_off;
        sub_off = idx - SUB_BASE;
        if (idx < SUB_BASE) begin
            sym = dev[idx[2:0]] ? SYM_LOW : SYM_FLOAT;
        end else if (idx < ON_IDX_A) begin
            sym = (sub_off == {1'b0, sub}) ? SYM_LOW : SYM_FLOAT;
        end else if (idx == ON_IDX_A) begin
            sym = on ? SYM_LOW : SYM_HIGH;
        end else if (idx == ON_IDX_B) begin
            sym = on ? SYM_HIGH : SYM_LOW;
        end else if (idx == SYNC_IDX) begin
            sym = SYM_SYNC;
        end else begin
            sym = SYM_ZERO;
        end
        return sym;
    endfunction

endpackage

// ===== src/remote_switch_frame_encoder_top.sv =====
// remote_switch_frame_encoder_top: stream-in, stream-out frame encoder with
// an apb register for the repeat count; depends on rsfe_pkg
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  tuser: operation, tdata: addr, sub, on
//  m_        out        m_tvalid / m_tready  tdata: data_out, busy_res, accepted
//  apb       in         psel+penable, pready always high, repeat_count at 0x0
//
// a result is offered once its input transfer has passed the input register and then the
// result register; store and counters update as it moves to the result register
// throughput is one transfer per cycle while the result side keeps taking them
// while a result waits, one more transfer fits if the input register is empty
// reset (aresetn low, synchronous) clears counters, pin, store and both stages
module remote_switch_frame_encoder_top
    import rsfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [4:0] device, [7:5] channel, [8] switch_on
    input  logic        s_tuser,   // [0] operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] data_out, [1] busy_res, [2] accepted
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // input stage
    logic             in_valid_reg;
    logic             in_op_reg;
    logic [DEV_W-1:0] in_dev_reg;
    logic [SUB_W-1:0] in_sub_reg;
    logic             in_on_reg;

    // encoder state
    symbol_t               symbol_reg [NUM_SYMBOLS];
    logic [SYM_IDX_W-1:0]  symbol_pos_reg, symbol_pos_next;
    logic [BIT_IDX_W-1:0]  bit_pos_reg, bit_pos_next;
    logic [REPEAT_W-1:0]   repeats_left_reg, repeats_left_next;
    logic                  pin_level_reg, pin_level_next;
    logic [REPEAT_W-1:0]   repeat_count_reg;

    // result stage
    logic       m_valid_reg;
    logic [2:0] m_data_reg;

    logic    out_ready;
    logic    advance;
    logic    send_ok;
    logic    tick_run;
    symbol_t cur_sym;
    logic    cfg_write;

    // handshake between the two stages
    assign out_ready = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_op_reg  <= s_tuser;
            in_dev_reg <= s_tdata[4:0];
            in_sub_reg <= s_tdata[7:5];
            in_on_reg  <= s_tdata[8];
        end
    end

    // decode of the held transfer
    assign send_ok  = (in_op_reg == OP_SEND) && (in_sub_reg <= SUB_ADDR_MAX);
    assign tick_run = (in_op_reg == OP_TICK) && (repeats_left_reg != '0);
    assign cur_sym  = symbol_reg[symbol_pos_reg];

    // counter and pin update
    always_comb begin
        symbol_pos_next   = symbol_pos_reg;
        bit_pos_next      = bit_pos_reg;
        repeats_left_next = repeats_left_reg;
        pin_level_next    = pin_level_reg;
        if (send_ok) begin
            symbol_pos_next   = '0;
            bit_pos_next      = '0;
            repeats_left_next = repeat_count_reg;
        end else if (tick_run) begin
            // msb first: bit 7 - bit_pos
            pin_level_next = cur_sym[LAST_BIT - bit_pos_reg];
            if (bit_pos_reg == LAST_BIT) begin
                bit_pos_next = '0;
                if (symbol_pos_reg == LAST_SYM) begin
                    symbol_pos_next   = '0;
                    repeats_left_next = repeats_left_reg - 1'b1;
                end else begin
                    symbol_pos_next = symbol_pos_reg + 1'b1;
                end
            end else begin
                bit_pos_next = bit_pos_reg + 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_pos_reg   <= '0;
            bit_pos_reg      <= '0;
            repeats_left_reg <= '0;
            pin_level_reg    <= 1'b0;
        end else if (advance) begin
            symbol_pos_reg   <= symbol_pos_next;
            bit_pos_reg      <= bit_pos_next;
            repeats_left_reg <= repeats_left_next;
            pin_level_reg    <= pin_level_next;
        end
    end

    // frame store, loaded in parallel on a valid send
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SYMBOLS; i++) begin
                symbol_reg[i] <= SYM_ZERO;
            end
        end else if (advance && send_ok) begin
            for (int i = 0; i < NUM_SYMBOLS; i++) begin
                symbol_reg[i] <= build_symbol(SYM_IDX_W'(i), in_dev_reg, in_sub_reg,
                                              in_on_reg);
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            m_data_reg <= {send_ok, (repeats_left_next != '0), pin_level_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_data_reg};

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_count_reg <= REPEAT_COUNT_RESET;
        end else if (cfg_write && (paddr[2] == REG_REPEAT_COUNT)) begin
            repeat_count_reg <= pwdata[REPEAT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_REPEAT_COUNT) ? {24'b0, repeat_count_reg} : 32'b0;

    // an idle tick leaves the pin and the positions alone
    a_idle_tick_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == OP_TICK && repeats_left_reg == '0) |=>
            ($stable(pin_level_reg) && $stable(bit_pos_reg) && $stable(symbol_pos_reg)))
        else $error("idle tick changed encoder state");

    // repeats only grow on a valid send
    a_repeats_no_growth: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !send_ok) |=> (repeats_left_reg <= $past(repeats_left_reg)))
        else $error("repeat counter grew without a send");

    // bit position steps by one inside a symbol
    a_bit_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && tick_run && bit_pos_reg != LAST_BIT) |=>
            (bit_pos_reg == $past(bit_pos_reg) + 1'b1) && $stable(symbol_pos_reg))
        else $error("bit position did not advance");

    // an accepted result always comes from a send transfer
    a_accept_from_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == OP_TICK) |=> !m_data_reg[2])
        else $error("tick transfer reported as accepted");

endmodule
